>>> src/dudec_pkg.sv
// Package: shared types, register indexes and edge-select codes for the edge counter.
package dudec_pkg;

  // Fixed field widths of the channels and configuration registers, and the queue depth
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned MODE_W     = 4;
  localparam int unsigned DEBOUNCE_W = 24;
  localparam int unsigned CFG_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_B_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd2;

  // Per-pin edge select bits
  localparam logic [1:0] EDGE_RISE = 2'b01;
  localparam logic [1:0] EDGE_FALL = 2'b10;
  localparam logic [1:0] EDGE_BOTH = 2'b11;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       operation;
    logic                      level_a;
    logic                      level_b;
    logic signed [DATA_W-1:0]  load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  count;
    logic                      up_accepted;
    logic                      down_accepted;
  } out_item_t;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    op_t                       op;
    logic                      edge_a;
    logic                      edge_b;
    logic signed [DATA_W-1:0]  load_value;
  } q_entry_t;

  // True when the level change matches the selected edge kinds
  function automatic logic edge_seen(input logic prev, input logic cur, input logic [1:0] sel);
    logic rise;
    logic fall;
    rise = ((sel & EDGE_RISE) != 2'b00) && !prev && cur;
    fall = ((sel & EDGE_FALL) != 2'b00) && prev && !cur;
    return rise || fall;
  endfunction

endpackage

>>> src/dudec_front.sv
// Front end: accepts pin samples and loads, tracks levels and flags qualified edges.
module dudec_front
  import dudec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  input  logic [MODE_W-1:0]     edge_mode,
  input  logic                  input_b_enable,
  input  logic                  q_full,
  output logic                  q_push,
  output q_entry_t              q_entry
);

  logic prev_a_r, prev_a_nxt;
  logic prev_b_r, prev_b_nxt;
  logic primed_r, primed_nxt;
  logic xfer;

  // Take a transfer whenever the queue has room
  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;
  assign q_push   = xfer;

  // Classify the item
  always_comb begin
    q_entry.op         = in_data.operation;
    q_entry.load_value = in_data.load_value;
    q_entry.edge_a     = primed_r && edge_seen(prev_a_r, in_data.level_a, edge_mode[1:0]);
    q_entry.edge_b     = primed_r && input_b_enable &&
                         edge_seen(prev_b_r, in_data.level_b, edge_mode[3:2]);
  end

  // Track levels on sample transfers; loads leave them alone
  always_comb begin
    prev_a_nxt = prev_a_r;
    prev_b_nxt = prev_b_r;
    primed_nxt = primed_r;
    if (xfer && in_data.operation == OP_SAMPLE) begin
      prev_a_nxt = in_data.level_a;
      prev_b_nxt = in_data.level_b;
      primed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r <= 1'b0;
      prev_b_r <= 1'b0;
      primed_r <= 1'b0;
    end else begin
      prev_a_r <= prev_a_nxt;
      prev_b_r <= prev_b_nxt;
      primed_r <= primed_nxt;
    end
  end

endmodule

>>> src/dudec_queue.sv
// Queue: short FIFO of classified items between the front and back ends.
module dudec_queue
  import dudec_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_entry,
  output logic      full,
  output logic      rd_valid,
  input  logic      pop,
  output q_entry_t  rd_entry
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  q_entry_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             do_pop;

  assign full     = (level_r == LVL_MAX);
  assign rd_valid = (level_r != '0);
  assign do_pop   = pop && rd_valid;
  assign rd_entry = mem_r[rd_ptr_r];

  // Advance pointers and level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_MAX)
    else $error("queue level above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_level_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !do_pop) |=> level_r == $past(level_r) + 1'b1)
    else $error("queue level did not grow on push");
`endif

endmodule

>>> src/dudec_back.sv
// Back end: debounce holdoffs, the up/down counter and the result register.
module dudec_back
  import dudec_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH   = 32,
  parameter int unsigned HOLDOFF_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  q_entry_t               q_entry,
  input  logic [DEBOUNCE_W-1:0]  debounce_ticks,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data
);

  localparam int unsigned MW = (HOLDOFF_WIDTH > DEBOUNCE_W) ? HOLDOFF_WIDTH : DEBOUNCE_W;
  localparam int unsigned LW = (COUNT_WIDTH > DATA_W) ? COUNT_WIDTH : DATA_W;
  localparam logic [HOLDOFF_WIDTH-1:0] HOLD_MAX = {HOLDOFF_WIDTH{1'b1}};

  logic [COUNT_WIDTH-1:0]   count_r, count_nxt;
  logic [HOLDOFF_WIDTH-1:0] hold_a_r, hold_a_nxt;
  logic [HOLDOFF_WIDTH-1:0] hold_b_r, hold_b_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic [HOLDOFF_WIDTH-1:0] hold_a_dec, hold_b_dec, hold_load;
  logic [MW-1:0]            deb_ext;
  logic [LW-1:0]            load_ext, count_ext;
  logic                     acc_a, acc_b, deb_off;

  // Pop when the result register is free or being emptied
  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // Holdoff reload value, saturated to the holdoff width
  assign deb_ext   = MW'(debounce_ticks);
  assign hold_load = (deb_ext > MW'(HOLD_MAX)) ? HOLD_MAX : HOLDOFF_WIDTH'(deb_ext);
  assign deb_off   = (debounce_ticks == '0);

  // Count holdoffs down, then qualify edges
  assign hold_a_dec = (hold_a_r != '0) ? hold_a_r - 1'b1 : hold_a_r;
  assign hold_b_dec = (hold_b_r != '0) ? hold_b_r - 1'b1 : hold_b_r;
  assign acc_a      = q_entry.edge_a && (deb_off || hold_a_dec == '0);
  assign acc_b      = q_entry.edge_b && (deb_off || hold_b_dec == '0);

  assign load_ext = LW'(q_entry.load_value);

  // Apply the popped item
  always_comb begin
    count_nxt     = count_r;
    hold_a_nxt    = hold_a_r;
    hold_b_nxt    = hold_b_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    count_ext     = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      out_valid_nxt = 1'b1;
      unique case (q_entry.op)
        OP_LOAD: begin
          count_nxt                  = COUNT_WIDTH'(load_ext);
          out_data_nxt.up_accepted   = 1'b0;
          out_data_nxt.down_accepted = 1'b0;
        end
        OP_SAMPLE: begin
          hold_a_nxt = acc_a ? hold_load : hold_a_dec;
          hold_b_nxt = acc_b ? hold_load : hold_b_dec;
          if (acc_a && !acc_b) begin
            count_nxt = count_r + 1'b1;
          end else if (acc_b && !acc_a) begin
            count_nxt = count_r - 1'b1;
          end
          out_data_nxt.up_accepted   = acc_a;
          out_data_nxt.down_accepted = acc_b;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
      count_ext          = LW'(count_nxt);
      out_data_nxt.count = DATA_W'(count_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      hold_a_r    <= '0;
      hold_b_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      hold_a_r    <= hold_a_nxt;
      hold_b_r    <= hold_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_load_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.op == OP_LOAD) |=>
      (!out_data_r.up_accepted && !out_data_r.down_accepted))
    else $error("load result carries edge flags");

  a_both_cancel: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.op == OP_SAMPLE && acc_a && acc_b) |=> count_r == $past(count_r))
    else $error("edges on both pins changed the count");

  a_holdoff_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_entry.op == OP_SAMPLE && acc_a && !deb_off) |=> hold_a_r != '0)
    else $error("holdoff A not armed after accepted edge");
`endif

endmodule

>>> src/debounced_up_down_edge_counter_top.sv
// Top level: configuration registers and the front end, queue and back end of the edge counter.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready    in_item_t  (operation, levels, load_value)
//   out_     output     out_valid / out_ready  out_item_t (count, up/down accepted flags)
//   cfg_     input      cfg_we                 cfg_index, cfg_wdata (no read-back)
//
// One item per cycle sustained while out_ready stays high; each item passes the queue stage, then the result register.
// The holdoff countdown and the counter update are computed together and registered in the back end.
// Synchronous active-low reset clears levels, holdoffs, count, registers and the queue.
// A stalled output fills the two-entry queue, after which in_ready drops.
module debounced_up_down_edge_counter_top
  import dudec_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH   = 32,
  parameter int unsigned HOLDOFF_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic [MODE_W-1:0]     edge_mode_r, edge_mode_nxt;
  logic                  b_enable_r, b_enable_nxt;
  logic [DEBOUNCE_W-1:0] debounce_r, debounce_nxt;

  logic     q_full, q_push, q_valid, q_pop;
  q_entry_t q_wr_entry, q_rd_entry;

  // Decode configuration writes; unknown indexes drop
  always_comb begin
    edge_mode_nxt = edge_mode_r;
    b_enable_nxt  = b_enable_r;
    debounce_nxt  = debounce_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_EDGE_MODE:      edge_mode_nxt = cfg_wdata[MODE_W-1:0];
        REG_INPUT_B_ENABLE: b_enable_nxt  = cfg_wdata[0];
        REG_DEBOUNCE_TICKS: debounce_nxt  = cfg_wdata[DEBOUNCE_W-1:0];
        default:            debounce_nxt  = debounce_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_mode_r <= '0;
      b_enable_r  <= 1'b0;
      debounce_r  <= '0;
    end else begin
      edge_mode_r <= edge_mode_nxt;
      b_enable_r  <= b_enable_nxt;
      debounce_r  <= debounce_nxt;
    end
  end

  dudec_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .edge_mode      (edge_mode_r),
    .input_b_enable (b_enable_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_wr_entry)
  );

  dudec_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_wr_entry),
    .full       (q_full),
    .rd_valid   (q_valid),
    .pop        (q_pop),
    .rd_entry   (q_rd_entry)
  );

  dudec_back #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .HOLDOFF_WIDTH (HOLDOFF_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_entry        (q_rd_entry),
    .debounce_ticks (debounce_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

>>> tb/sv/debounced_up_down_edge_counter_top_test.sv
// Self-checking testbench for the debounced up/down edge counter.
`timescale 1ns / 100ps

module debounced_up_down_edge_counter_top_test;
  import dudec_pkg::*;

  // Index with no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned N_PHASES   = 16;
  localparam int unsigned PHASE_LEN  = 40;
  localparam int unsigned SETTLE_CYC = 4;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // One row of the directed stimulus: a register write or an item
  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_data;
    in_item_t             item;
    bit                   typed;
    out_item_t            want;
  } step_t;

  // Mirror of the counter state and its registers
  logic signed [DATA_W-1:0]     tally = '0;
  logic                         last_a = 1'b0;
  logic                         last_b = 1'b0;
  logic                         primed = 1'b0;
  logic [DEBOUNCE_W-1:0]        hold_a = '0;
  logic [DEBOUNCE_W-1:0]        hold_b = '0;
  logic [MODE_W-1:0]            mode_r = '0;
  logic                         b_en_r = 1'b0;
  logic [DEBOUNCE_W-1:0]        debounce_r = '0;

  out_item_t    pending_counts[$];
  step_t        dir_tab[$];
  int unsigned  err_cnt = 0;
  int unsigned  send_idle = 9;
  int unsigned  recv_idle = 47;
  bit           cfg_on = 1'b0;

  debounced_up_down_edge_counter_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Level change that the two select bits qualify
  function automatic logic pin_moved(input logic was, input logic now_lvl,
                                     input logic [1:0] sel);
    return (sel[0] & ~was & now_lvl) | (sel[1] & was & ~now_lvl);
  endfunction

  // Count the holdoff down, then accept the edge if debouncing lets it through
  function automatic logic holdoff_pass(inout logic [DEBOUNCE_W-1:0] hold,
                                        input logic seen);
    if (hold != '0)
      hold = hold - 1'b1;
    if (!seen)
      return 1'b0;
    if (debounce_r != '0 && hold != '0)
      return 1'b0;
    hold = debounce_r;
    return 1'b1;
  endfunction

  // Advance the mirrored counter by one item and return its result
  function automatic out_item_t next_count(input in_item_t item);
    out_item_t res;
    logic      ea;
    logic      eb;
    logic      up;
    logic      dn;
    res = '0;
    if (item.operation == OP_LOAD) begin
      tally = item.load_value;
    end else begin
      ea = primed && pin_moved(last_a, item.level_a, mode_r[1:0]);
      eb = primed && b_en_r && pin_moved(last_b, item.level_b, mode_r[3:2]);
      up = holdoff_pass(hold_a, ea);
      dn = holdoff_pass(hold_b, eb);
      if (up && !dn)
        tally = tally + 1;
      else if (dn && !up)
        tally = tally - 1;
      last_a = item.level_a;
      last_b = item.level_b;
      primed = 1'b1;
      res.up_accepted   = up;
      res.down_accepted = dn;
    end
    res.count = tally;
    return res;
  endfunction

  function automatic void mirror_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] data);
    case (idx)
      REG_EDGE_MODE:      mode_r = data[MODE_W-1:0];
      REG_INPUT_B_ENABLE: b_en_r = data[0];
      REG_DEBOUNCE_TICKS: debounce_r = data[DEBOUNCE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic step_t tick_row(input bit a, input bit b);
    step_t s;
    s = '{default: '0};
    s.item.operation = OP_SAMPLE;
    s.item.level_a   = a;
    s.item.level_b   = b;
    return s;
  endfunction

  function automatic step_t tick_exp_row(input bit a, input bit b, input logic [31:0] c,
                                         input bit u, input bit d);
    step_t s;
    s = tick_row(a, b);
    s.typed              = 1'b1;
    s.want.count         = c;
    s.want.up_accepted   = u;
    s.want.down_accepted = d;
    return s;
  endfunction

  function automatic step_t load_row(input logic [31:0] v);
    step_t s;
    s = '{default: '0};
    s.item.operation = OP_LOAD;
    s.item.load_value = v;
    s.typed      = 1'b1;
    s.want.count = v;
    return s;
  endfunction

  function automatic step_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
    step_t s;
    s = '{default: '0};
    s.is_write = 1'b1;
    s.reg_idx  = idx;
    s.reg_data = data;
    return s;
  endfunction

  // Wait until every result is back, then cover the pipeline latency
  task automatic settle();
    while (pending_counts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write one register; back-to-back writes keep the enable high
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    if (!cfg_on) begin
      in_valid <= 1'b0;
      settle();
    end
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    mirror_reg(idx, data);
    cfg_on = 1'b1;
  endtask

  // Offer one item and hold it until the transfer
  task automatic send_item(input in_item_t item, input bit typed, input out_item_t want);
    out_item_t got;
    if (cfg_on) begin
      cfg_we <= 1'b0;
      cfg_on = 1'b0;
    end
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    got = next_count(item);
    pending_counts.push_back(typed ? want : got);
  endtask

  // Receiver stalls
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle);

  // Compare each result transfer with the oldest expected count
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_counts.size() == 0) begin
        $error("unexpected result: count %0d", out_data.count);
        err_cnt++;
      end else begin
        want = pending_counts.pop_front();
        if (out_data.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data.count);
          err_cnt++;
        end
        if (out_data.up_accepted !== want.up_accepted) begin
          $error("up_accepted: expected %0b, got %0b", want.up_accepted,
                 out_data.up_accepted);
          err_cnt++;
        end
        if (out_data.down_accepted !== want.down_accepted) begin
          $error("down_accepted: expected %0b, got %0b", want.down_accepted,
                 out_data.down_accepted);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    in_item_t    item;
    out_item_t   none;
    bit          lvl_a;
    bit          lvl_b;
    logic [CFG_W-1:0] deb;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    none  = '0;
    lvl_a = 1'b0;
    lvl_b = 1'b0;

    // Reset defaults: first sample only primes, then no edge kind selected
    dir_tab.push_back(tick_exp_row(1'b1, 1'b1, 32'h0, 1'b0, 1'b0));
    dir_tab.push_back(tick_exp_row(1'b0, 1'b0, 32'h0, 1'b0, 1'b0));
    // Both edge kinds on both pins, no debounce: up, down, cancel, wrap
    dir_tab.push_back(reg_row(REG_EDGE_MODE, 24'hF));
    dir_tab.push_back(reg_row(REG_INPUT_B_ENABLE, 24'h1));
    dir_tab.push_back(reg_row(REG_DEBOUNCE_TICKS, 24'h0));
    dir_tab.push_back(tick_row(1'b1, 1'b0));
    dir_tab.push_back(tick_row(1'b1, 1'b1));
    dir_tab.push_back(tick_row(1'b0, 1'b0));
    dir_tab.push_back(load_row(32'h7FFF_FFFF));
    dir_tab.push_back(tick_row(1'b1, 1'b0));
    dir_tab.push_back(load_row(32'h8000_0000));
    dir_tab.push_back(tick_row(1'b1, 1'b1));
    dir_tab.push_back(load_row(32'hFFFF_FFFF));
    dir_tab.push_back(load_row(32'h0));
    // Rising only, B disabled, three-tick holdoff
    dir_tab.push_back(reg_row(REG_EDGE_MODE, 24'h5));
    dir_tab.push_back(reg_row(REG_INPUT_B_ENABLE, 24'h0));
    dir_tab.push_back(reg_row(REG_DEBOUNCE_TICKS, 24'h3));
    dir_tab.push_back(tick_row(1'b0, 1'b0));
    dir_tab.push_back(tick_row(1'b1, 1'b1));
    dir_tab.push_back(tick_row(1'b0, 1'b0));
    dir_tab.push_back(tick_row(1'b1, 1'b0));
    dir_tab.push_back(tick_row(1'b0, 1'b0));
    dir_tab.push_back(tick_row(1'b1, 1'b1));
    // Falling only, longest debounce while a holdoff runs, dropped spare write
    dir_tab.push_back(reg_row(REG_EDGE_MODE, 24'hA));
    dir_tab.push_back(reg_row(REG_DEBOUNCE_TICKS, 24'hFF_FFFF));
    dir_tab.push_back(reg_row(REG_SPARE, 24'hFF_FFFF));
    dir_tab.push_back(tick_row(1'b0, 1'b0));
    dir_tab.push_back(tick_row(1'b1, 1'b1));
    dir_tab.push_back(tick_row(1'b0, 1'b0));
    // Debounce off takes effect at once; accepted edges clear the holdoffs
    dir_tab.push_back(reg_row(REG_DEBOUNCE_TICKS, 24'h0));
    dir_tab.push_back(reg_row(REG_EDGE_MODE, 24'hF));
    dir_tab.push_back(reg_row(REG_INPUT_B_ENABLE, 24'h1));
    dir_tab.push_back(tick_row(1'b1, 1'b1));
    dir_tab.push_back(tick_row(1'b0, 1'b1));
    dir_tab.push_back(tick_row(1'b1, 1'b0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_write)
        put_reg(dir_tab[i].reg_idx, dir_tab[i].reg_data);
      else
        send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
    end
    lvl_a = 1'b1;
    lvl_b = 1'b0;

    // Random phases, each under a fresh register setting
    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 6) begin
        send_idle = 9;
        recv_idle = 47;
      end else if (p < 11) begin
        send_idle = 47;
        recv_idle = 9;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case ($urandom_range(9))
        0, 1:    deb = '0;
        8:       deb = CFG_W'($urandom_range(40, 7));
        9:       deb = CFG_W'($urandom);
        default: deb = CFG_W'($urandom_range(6, 1));
      endcase
      if (p % 4 == 0)
        put_reg(REG_EDGE_MODE, (p % 8 == 0) ? 24'h0 : 24'hF);
      else
        put_reg(REG_EDGE_MODE, CFG_W'($urandom_range(15)));
      put_reg(REG_INPUT_B_ENABLE, CFG_W'($urandom_range(1)));
      put_reg(REG_DEBOUNCE_TICKS, deb);
      if ($urandom_range(3) == 0)
        put_reg(REG_SPARE, CFG_W'($urandom));

      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(99) < 40)
          lvl_a = ~lvl_a;
        if ($urandom_range(99) < 40)
          lvl_b = ~lvl_b;
        item.operation = ($urandom_range(99) < 8) ? OP_LOAD : OP_SAMPLE;
        item.level_a   = lvl_a;
        item.level_b   = lvl_b;
        case ($urandom_range(5))
          0:       item.load_value = 32'h7FFF_FFFF;
          1:       item.load_value = 32'h8000_0000;
          2:       item.load_value = 32'hFFFF_FFFF;
          default: item.load_value = $urandom;
        endcase
        send_item(item, 1'b0, none);
      end
    end

    if (cfg_on)
      cfg_we <= 1'b0;
    in_valid <= 1'b0;
    settle();
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && pending_counts.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
